// ===== design/quiesce_handshake_controller_core_defines.svh =====
// assertion macros shared by the quiesce handshake controller files
`ifndef QUIESCE_HANDSHAKE_CONTROLLER_CORE_DEFINES_SVH
`define QUIESCE_HANDSHAKE_CONTROLLER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

`define QHC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

`define QHC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`else

`define QHC_ASSERT(lbl, clk, rstn, prop)

`define QHC_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ===== design/qhc_pkg.sv =====
// types and constants of the quiesce handshake controller
package qhc_pkg;

  localparam int unsigned NumSubsys = 5;
  localparam int unsigned KindW     = 3;
  localparam int unsigned AckW      = 5;
  localparam int unsigned FlagW     = 5;
  localparam int unsigned BcastW    = 2;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned CntW      = 32;
  localparam int unsigned StepW     = 16;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned CfgIdxW   = 1;

  localparam logic [AckW-1:0] AllMask =
    (NumSubsys >= AckW) ? {AckW{1'b1}} : AckW'((64'd1 << NumSubsys) - 64'd1);

  localparam logic [FlagW-1:0] FlagRunning  = 5'b00001;
  localparam logic [FlagW-1:0] FlagQreq     = 5'b00010;
  localparam logic [FlagW-1:0] FlagQuiesced = 5'b00100;
  localparam logic [FlagW-1:0] FlagResume   = 5'b01000;
  localparam logic [FlagW-1:0] FlagTimeout  = 5'b10000;

  localparam logic [TimeW-1:0] TimeoutLimitRst = 32'd1000;
  localparam logic [StepW-1:0] PollStepRst     = 16'd10;
  localparam logic [CntW-1:0]  CntMax          = 32'hFFFF_FFFF;

  typedef enum logic [KindW-1:0] {
    KindQuiesceReq    = 3'd0,
    KindResume        = 3'd1,
    KindAck           = 3'd2,
    KindIdlePoll      = 3'd3,
    KindQueueFault    = 3'd4,
    KindInputActivity = 3'd5,
    KindMenu          = 3'd6,
    KindPerfHint      = 3'd7
  } kind_e;

  typedef enum logic [BcastW-1:0] {
    BcastNone    = 2'd0,
    BcastQuiesce = 2'd1,
    BcastResume  = 2'd2
  } bcast_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgTimeoutLimit = 1'd0,
    CfgPollStep     = 1'd1
  } cfg_idx_e;

  typedef struct packed {
    kind_e            kind;
    logic [AckW-1:0]  ack_bits;
    logic             post_failed;
    logic [TimeW-1:0] event_time;
  } qhc_item_t;

  typedef struct packed {
    logic [FlagW-1:0] status_flags;
    logic [AckW-1:0]  pending_acks;
    logic             waiting;
    bcast_e           broadcast;
    logic [CntW-1:0]  activity_count;
    logic [CntW-1:0]  menu_count;
    logic [CntW-1:0]  hint_count;
    logic [TimeW-1:0] last_activity_time;
  } qhc_result_t;

endpackage

// ===== design/qhc_if.sv =====
// request and result channel interfaces of the quiesce handshake controller
interface qhc_req_if import qhc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KindW-1:0] kind;
  logic [AckW-1:0]  ack_bits;
  logic             post_failed;
  logic [TimeW-1:0] event_time;

  modport source (output valid, output kind, output ack_bits, output post_failed,
                  output event_time, input ready);
  modport sink (input valid, input kind, input ack_bits, input post_failed,
                input event_time, output ready);
endinterface

interface qhc_rsp_if import qhc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FlagW-1:0]  status_flags;
  logic [AckW-1:0]   pending_acks;
  logic              waiting;
  logic [BcastW-1:0] broadcast;
  logic [CntW-1:0]   activity_count;
  logic [CntW-1:0]   menu_count;
  logic [CntW-1:0]   hint_count;
  logic [TimeW-1:0]  last_activity_time;

  modport source (output valid, output status_flags, output pending_acks, output waiting,
                  output broadcast, output activity_count, output menu_count,
                  output hint_count, output last_activity_time, input ready);
  modport sink (input valid, input status_flags, input pending_acks, input waiting,
                input broadcast, input activity_count, input menu_count,
                input hint_count, input last_activity_time, output ready);
endinterface

// ===== design/quiesce_handshake_controller_core.sv =====
// quiesce handshake controller: top level
// a request is held in the request register and its result in the result register
// throughput: one request per cycle while the result channel is ready, set by the state
// update between the request register and the result register
// reset: handshake state, flags and counters clear, timeout limit 1000, poll step 10
module quiesce_handshake_controller_core import qhc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  qhc_req_if.sink             req,
  qhc_rsp_if.source           rsp,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  logic        stage_valid;
  qhc_item_t   stage_item;
  logic        out_space;
  logic        adv;
  qhc_result_t result;

  assign adv = stage_valid && out_space;

  qhc_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req     (req),
    .adv_i   (adv),
    .valid_o (stage_valid),
    .item_o  (stage_item)
  );

  qhc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .adv_i       (adv),
    .item_i      (stage_item),
    .result_o    (result)
  );

  qhc_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .result_i (result),
    .space_o  (out_space),
    .rsp      (rsp)
  );

endmodule

// ===== design/qhc_in_stage.sv =====
// input register stage holding one accepted request
module qhc_in_stage import qhc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  qhc_req_if.sink   req,
  input  logic      adv_i,
  output logic      valid_o,
  output qhc_item_t item_o
);

  logic      valid_q, valid_d;
  qhc_item_t item_q;
  logic      take;

  assign req.ready = !valid_q || adv_i;
  assign take      = req.valid && req.ready;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (adv_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.kind        <= kind_e'(req.kind);
      item_q.ack_bits    <= req.ack_bits;
      item_q.post_failed <= req.post_failed;
      item_q.event_time  <= req.event_time;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== design/qhc_ctrl.sv =====
// handshake state, counters, configuration and per-request update logic
`include "quiesce_handshake_controller_core_defines.svh"

module qhc_ctrl import qhc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                adv_i,
  input  qhc_item_t           item_i,
  output qhc_result_t         result_o
);

  logic [TimeW-1:0] limit_q;
  logic [StepW-1:0] step_q;
  logic [FlagW-1:0] flags_q, flags_d;
  logic [AckW-1:0]  pending_q, pending_d;
  logic             wait_q, wait_d;
  logic [TimeW-1:0] elapsed_q, elapsed_d;
  logic [CntW-1:0]  act_cnt_q, act_cnt_d;
  logic [CntW-1:0]  menu_cnt_q, menu_cnt_d;
  logic [CntW-1:0]  hint_cnt_q, hint_cnt_d;
  logic [TimeW-1:0] stamp_q, stamp_d;
  bcast_e           bcast;
  logic [AckW-1:0]  pend_ack;
  logic [TimeW:0]   remain;
  logic             at_limit;
  logic             near_limit;

  assign pend_ack   = pending_q & ~(item_i.ack_bits & AllMask);
  assign remain     = {1'b0, limit_q} - {1'b0, elapsed_q};
  assign at_limit   = remain[TimeW] || (remain[TimeW-1:0] == '0);
  assign near_limit = remain[TimeW-1:0] <= {{(TimeW-StepW){1'b0}}, step_q};

  always_comb begin
    flags_d    = flags_q;
    pending_d  = pending_q;
    wait_d     = wait_q;
    elapsed_d  = elapsed_q;
    act_cnt_d  = act_cnt_q;
    menu_cnt_d = menu_cnt_q;
    hint_cnt_d = hint_cnt_q;
    stamp_d    = stamp_q;
    bcast      = BcastNone;
    case (item_i.kind)
      KindQuiesceReq: begin
        bcast     = BcastQuiesce;
        elapsed_d = '0;
        if (item_i.post_failed) begin
          pending_d = '0;
          wait_d    = 1'b0;
          flags_d   = FlagQreq | FlagTimeout;
        end else begin
          pending_d = AllMask;
          wait_d    = 1'b1;
          flags_d   = FlagQreq;
        end
      end
      KindResume: begin
        bcast     = BcastResume;
        pending_d = '0;
        wait_d    = 1'b0;
        elapsed_d = '0;
        flags_d   = FlagResume | FlagRunning;
      end
      KindAck: begin
        if (wait_q) begin
          pending_d = pend_ack;
          if (pend_ack == '0) begin
            wait_d    = 1'b0;
            elapsed_d = '0;
            flags_d   = flags_q | FlagQuiesced;
          end
        end
      end
      KindIdlePoll: begin
        if (wait_q && (pending_q != '0)) begin
          if (at_limit || near_limit) begin
            if (!at_limit) begin
              elapsed_d = limit_q;
            end
            wait_d    = 1'b0;
            pending_d = '0;
            flags_d   = (flags_q & ~FlagQuiesced) | FlagTimeout;
          end else begin
            elapsed_d = elapsed_q + {{(TimeW-StepW){1'b0}}, step_q};
          end
        end
      end
      KindQueueFault: begin
        pending_d = '0;
        wait_d    = 1'b0;
        elapsed_d = '0;
        flags_d   = FlagRunning;
      end
      KindInputActivity: begin
        act_cnt_d = act_cnt_q + 1'b1;
        stamp_d   = item_i.event_time;
      end
      KindMenu: begin
        menu_cnt_d = menu_cnt_q + 1'b1;
      end
      KindPerfHint: begin
        if (hint_cnt_q != CntMax) begin
          hint_cnt_d = hint_cnt_q + 1'b1;
        end
      end
      default: begin
        bcast = BcastNone;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= TimeoutLimitRst;
      step_q  <= PollStepRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgTimeoutLimit: limit_q <= cfg_wdata_i[TimeW-1:0];
        CfgPollStep:     step_q  <= cfg_wdata_i[StepW-1:0];
        default:         limit_q <= limit_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q    <= '0;
      pending_q  <= '0;
      wait_q     <= 1'b0;
      elapsed_q  <= '0;
      act_cnt_q  <= '0;
      menu_cnt_q <= '0;
      hint_cnt_q <= '0;
      stamp_q    <= '0;
    end else if (adv_i) begin
      flags_q    <= flags_d;
      pending_q  <= pending_d;
      wait_q     <= wait_d;
      elapsed_q  <= elapsed_d;
      act_cnt_q  <= act_cnt_d;
      menu_cnt_q <= menu_cnt_d;
      hint_cnt_q <= hint_cnt_d;
      stamp_q    <= stamp_d;
    end
  end

  assign result_o.status_flags       = flags_d;
  assign result_o.pending_acks       = pending_d;
  assign result_o.waiting            = wait_d;
  assign result_o.broadcast          = bcast;
  assign result_o.activity_count     = act_cnt_d;
  assign result_o.menu_count         = menu_cnt_d;
  assign result_o.hint_count         = hint_cnt_d;
  assign result_o.last_activity_time = stamp_d;

  // a wait is active exactly while some subsystem still owes an acknowledge
  `QHC_ASSERT(a_wait_pending, clk_i, rst_ni, wait_q == (pending_q != '0))
  // quiesced and timed out never stand together
  `QHC_ASSERT(a_quiesce_excl, clk_i, rst_ni, !(((flags_q & FlagQuiesced) != '0) && ((flags_q & FlagTimeout) != '0)))
  // quiesced is only reached after the wait has ended
  `QHC_ASSERT(a_quiesced_idle, clk_i, rst_ni, ((flags_q & FlagQuiesced) != '0) |-> !wait_q)

endmodule

// ===== design/qhc_out_stage.sv =====
// result register stage driving the result channel
`include "quiesce_handshake_controller_core_defines.svh"

module qhc_out_stage import qhc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  qhc_result_t result_i,
  output logic        space_o,
  qhc_rsp_if.source   rsp
);

  logic        valid_q, valid_d;
  qhc_result_t result_q;

  assign space_o = !valid_q || rsp.ready;

  always_comb begin
    valid_d = valid_q;
    if (adv_i) begin
      valid_d = 1'b1;
    end else if (rsp.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      result_q <= result_i;
    end
  end

  assign rsp.valid              = valid_q;
  assign rsp.status_flags       = result_q.status_flags;
  assign rsp.pending_acks       = result_q.pending_acks;
  assign rsp.waiting            = result_q.waiting;
  assign rsp.broadcast          = result_q.broadcast;
  assign rsp.activity_count     = result_q.activity_count;
  assign rsp.menu_count         = result_q.menu_count;
  assign rsp.hint_count         = result_q.hint_count;
  assign rsp.last_activity_time = result_q.last_activity_time;

  // a request moved in is always presented next cycle
  `QHC_ASSERT(a_adv_shows, clk_i, rst_ni, adv_i |=> valid_q)

endmodule
